/* src/bsnl_pkg.sv */
// Shared types and constants for the bounded sorted neighbour list.
// No dependencies; imported by bsnl_cell and bounded_sorted_neighbor_list_unit.
package bsnl_pkg;

    localparam int KeyW           = 32;
    localparam int FieldIdxW      = 16;
    localparam int RposW          = 6;
    localparam int CountFieldW    = 7;
    localparam int OpW            = 2;
    localparam int InDataW        = 56;
    localparam int OutDataW       = 64;

    localparam int DefCapacity    = 64;
    localparam int DefIndexBits   = 16;

    localparam logic [OpW-1:0] OP_INSERT = 2'd0;
    localparam logic [OpW-1:0] OP_READ   = 2'd1;
    localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic            ins;   // insert committed this cycle
        logic            rd;    // read operation present
        logic [KeyW-1:0] key;   // key under test / being inserted
    } t_cell_ctrl;

    // per-cell comparison result
    typedef struct packed {
        logic ahead;            // this cell stays ahead of the new entry
        logic le;               // valid and stored key <= new key
    } t_cell_stat;

endpackage

/* src/bounded_sorted_neighbor_list_unit.sv */
// Top level of the bounded sorted neighbour list: control, count, output register.
// Depends on bsnl_pkg and bsnl_cell.
//
// Usage:
//   Slave channel: tuser = operation (0 insert, 1 read, 2 clear, 3 ignored);
//   tdata = neighbour index, sort key, read position. Master channel returns
//   one transfer per input transfer with the count, accept/evict flags and
//   the read entry.
//   The list is a row of CAPACITY cells, one per rank. Every cell compares
//   its key with the incoming key in parallel and either holds, takes the
//   new entry or takes its left neighbour's entry.
//   Latency: the result appears in the output register the cycle after the
//   input transfer. Throughput: one item per cycle while the master side
//   takes results.
//   Stall: while a result waits unaccepted, the slave side is held off;
//   tready follows the output register being free or being drained.
//   Reset (synchronous, active low) empties the list and the output register;
//   stored keys are not cleared, the count alone marks valid ranks.
module bounded_sorted_neighbor_list_unit
    import bsnl_pkg::*;
#(
    parameter int CAPACITY   = DefCapacity,
    parameter int INDEX_BITS = DefIndexBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [15:0] neighbor_index, [47:16] sort_key, [53:48] read_position, [55:54] zero
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [OpW-1:0]      i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [6:0] entry_count, [7] accepted, [8] evicted, [24:9] out_index,
    // [56:25] out_key, [57] out_valid, [63:58] zero
    output logic [OutDataW-1:0] o_m_axis_tdata
);

    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int IdxW = (INDEX_BITS < FieldIdxW) ? INDEX_BITS : FieldIdxW;
    localparam int CmpW = (CntW > RposW) ? CntW : RposW;

    logic                 in_fire;
    logic [OpW-1:0]       op;
    logic [IdxW-1:0]      new_idx;
    logic [KeyW-1:0]      new_key;
    logic [RposW-1:0]     rpos;

    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      n_count;
    logic                 full;
    logic                 ins_ok;
    logic                 evict;
    logic                 rd_valid;

    logic                 r_out_vld;
    logic [OutDataW-1:0]  r_out_data;
    logic [OutDataW-1:0]  n_out_data;

    t_cell_ctrl           ctrl;
    t_cell_stat           stat     [CAPACITY];
    logic [CAPACITY-1:0]  ahead_v;
    logic [KeyW-1:0]      cell_key [CAPACITY];
    logic [IdxW-1:0]      cell_idx [CAPACITY];
    logic [KeyW-1:0]      rk       [CAPACITY];
    logic [IdxW-1:0]      ri       [CAPACITY];
    logic [KeyW-1:0]      rd_key;
    logic [IdxW-1:0]      rd_idx;

    assign op      = i_s_axis_tuser;
    assign new_idx = i_s_axis_tdata[IdxW-1:0];
    assign new_key = i_s_axis_tdata[47:16];
    assign rpos    = i_s_axis_tdata[53:48];

    assign o_s_axis_tready = !r_out_vld || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign full   = (r_count == CntW'(CAPACITY));
    // full list rejects a key at or above the largest stored one
    assign ins_ok = (op == OP_INSERT) && !(full && stat[CAPACITY-1].le);
    assign evict  = ins_ok && full;

    assign ctrl.ins = in_fire && ins_ok;
    assign ctrl.rd  = (op == OP_READ);
    assign ctrl.key = new_key;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [CntW-1:0] PosC = CntW'(g);
            logic              valid;
            logic              left_ahead;
            logic [KeyW-1:0]   left_key;
            logic [IdxW-1:0]   left_idx;

            assign valid = PosC < r_count;
            if (g == 0) begin : g_head
                assign left_ahead = 1'b0;
                assign left_key   = new_key;
                assign left_idx   = new_idx;
            end else begin : g_body
                assign left_ahead = stat[g-1].ahead;
                assign left_key   = cell_key[g-1];
                assign left_idx   = cell_idx[g-1];
            end

            bsnl_cell #(
                .POS   (g),
                .IDX_W (IdxW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_new_idx     (new_idx),
                .i_valid       (valid),
                .i_rpos        (rpos),
                .i_left_ahead  (left_ahead),
                .i_left_key    (left_key),
                .i_left_idx    (left_idx),
                .o_stat        (stat[g]),
                .o_key         (cell_key[g]),
                .o_idx         (cell_idx[g]),
                .o_rd_key      (rk[g]),
                .o_rd_idx      (ri[g])
            );

            assign ahead_v[g] = stat[g].ahead;
        end
    endgenerate

    // at most one cell drives its entry, the rest give zero
    always_comb begin
        rd_key = '0;
        rd_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_key = rd_key | rk[i];
            rd_idx = rd_idx | ri[i];
        end
    end

    assign rd_valid = ctrl.rd && (CmpW'(rpos) < CmpW'(r_count));

    always_comb begin
        n_count = r_count;
        if (op == OP_CLEAR) begin
            n_count = '0;
        end else if (ins_ok && !full) begin
            n_count = r_count + CntW'(1);
        end
    end

    always_comb begin
        n_out_data        = '0;
        n_out_data[6:0]   = CountFieldW'(n_count);
        n_out_data[7]     = ins_ok;
        n_out_data[8]     = evict;
        n_out_data[24:9]  = FieldIdxW'(rd_idx);
        n_out_data[56:25] = rd_key;
        n_out_data[57]    = rd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_count))
        else $error("entry count changed without a transfer");

    // ranks ahead of the insertion point form an unbroken prefix
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ahead_v >> 1) & ~ahead_v) == '0)
        else $error("list order broken");

    a_evict_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_data[8] |-> r_out_data[7])
        else $error("eviction without acceptance");

endmodule

/* src/bsnl_cell.sv */
// One rank of the sorted list: holds a key and identifier, compares against
// the broadcast key and takes the new entry or its left neighbour. Uses bsnl_pkg.
module bsnl_cell
    import bsnl_pkg::*;
#(
    parameter int POS   = 0,
    parameter int IDX_W = DefIndexBits
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_new_idx,
    input  logic              i_valid,
    input  logic [RposW-1:0]  i_rpos,
    input  logic              i_left_ahead,
    input  logic [KeyW-1:0]   i_left_key,
    input  logic [IDX_W-1:0]  i_left_idx,
    output t_cell_stat        o_stat,
    output logic [KeyW-1:0]   o_key,
    output logic [IDX_W-1:0]  o_idx,
    output logic [KeyW-1:0]   o_rd_key,
    output logic [IDX_W-1:0]  o_rd_idx
);

    logic [KeyW-1:0]  r_key;
    logic [IDX_W-1:0] r_idx;
    logic             lt;
    logic             eq;
    logic             sel;

    assign lt = i_valid && (r_key < i_ctrl.key);
    assign eq = i_valid && (r_key == i_ctrl.key);

    // an equal head keeps its place: the new entry lands right behind it
    assign o_stat.ahead = (POS == 0) ? (lt || eq) : lt;
    assign o_stat.le    = lt || eq;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && !o_stat.ahead) begin
            if (POS == 0 || i_left_ahead) begin
                r_key <= i_ctrl.key;
                r_idx <= i_new_idx;
            end else begin
                r_key <= i_left_key;
                r_idx <= i_left_idx;
            end
        end
    end

    assign o_key = r_key;
    assign o_idx = r_idx;

    assign sel      = i_ctrl.rd && i_valid && (32'(i_rpos) == 32'(POS));
    assign o_rd_key = sel ? r_key : '0;
    assign o_rd_idx = sel ? r_idx : '0;

endmodule

/* test/tb_bounded_sorted_neighbor_list_unit.sv */
// Self-checking testbench for bounded_sorted_neighbor_list_unit: streams insert, read and
// clear transfers under random flow control and checks every result against a local model.
// Depends on bsnl_pkg and the unit's RTL.
module tb_bounded_sorted_neighbor_list_unit;
    import bsnl_pkg::*;

    localparam logic [OpW-1:0] OP_IGNORED = 2'd3;
    localparam int ListDepth = DefCapacity;
    localparam int ItemTarget = 750;

    typedef struct packed {
        logic [CountFieldW-1:0] entry_count;
        logic                   accepted;
        logic                   evicted;
        logic [FieldIdxW-1:0]   out_index;
        logic [KeyW-1:0]        out_key;
        logic                   out_valid;
    } t_list_result;

    // Tracks the list contents and queues the result each transfer should produce.
    class t_sorted_list_tracker;
        logic [KeyW-1:0]      keys [ListDepth];
        logic [FieldIdxW-1:0] idxs [ListDepth];
        int                   fill;
        t_list_result         expected_results[$];
        int                   mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function void take_item(logic [OpW-1:0] op, logic [FieldIdxW-1:0] idx,
                                logic [KeyW-1:0] key, logic [RposW-1:0] rpos);
            t_list_result r;
            int rank;
            int last;
            bit full;
            r = '0;
            case (op)
                OP_INSERT: begin
                    full = (fill >= ListDepth);
                    if (!full || key < keys[ListDepth-1]) begin
                        rank = 0;
                        while (rank < fill && keys[rank] < key) rank++;
                        // an equal head keeps its place; the newcomer goes behind it
                        if (rank == 0 && fill > 0 && keys[0] == key) rank = 1;
                        if (full) begin
                            r.evicted = 1'b1;
                            last = ListDepth - 1;
                        end else begin
                            last = fill;
                            fill++;
                        end
                        if (rank > last) rank = last;
                        for (int i = last; i > rank; i--) begin
                            keys[i] = keys[i-1];
                            idxs[i] = idxs[i-1];
                        end
                        keys[rank] = key;
                        idxs[rank] = idx;
                        r.accepted = 1'b1;
                    end
                end
                OP_READ: begin
                    if (rpos < fill) begin
                        r.out_valid = 1'b1;
                        r.out_index = idxs[rpos];
                        r.out_key   = keys[rpos];
                    end
                end
                OP_CLEAR: fill = 0;
                default: ;
            endcase
            r.entry_count = fill[CountFieldW-1:0];
            expected_results.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
            if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_result(logic [OutDataW-1:0] data);
            t_list_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result 0x%0h with nothing outstanding", data));
            end else begin
                want = expected_results.pop_front();
                check_field("entry_count", KeyW'(data[6:0]), KeyW'(want.entry_count));
                check_field("accepted", KeyW'(data[7]), KeyW'(want.accepted));
                check_field("evicted", KeyW'(data[8]), KeyW'(want.evicted));
                check_field("out_index", KeyW'(data[24:9]), KeyW'(want.out_index));
                check_field("out_key", data[56:25], want.out_key);
                check_field("out_valid", KeyW'(data[57]), KeyW'(want.out_valid));
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [InDataW-1:0]  i_s_axis_tdata = '0;
    logic [OpW-1:0]      i_s_axis_tuser = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0] o_m_axis_tdata;

    t_sorted_list_tracker sb = new();
    int burst_left = 0;
    int items_sent = 0;
    int rx_mode = 0;
    int rx_left = 0;
    logic [2:0] rx_phase = '0;

    bounded_sorted_neighbor_list_unit #(
        .CAPACITY   (DefCapacity),
        .INDEX_BITS (DefIndexBits)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // input transfer is noted before the result check; a result never pairs with
    // an input taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.take_item(i_s_axis_tuser, i_s_axis_tdata[15:0], i_s_axis_tdata[47:16],
                             i_s_axis_tdata[53:48]);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
    end

    // receiver back-pressure: modes of random length, from always ready to long stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_phase <= rx_phase + 3'd1;
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= (rx_phase[1:0] != 2'd0);
            2: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= (rx_phase == 3'd0);
        endcase
    end

    task automatic send_item(input logic [OpW-1:0] op, input logic [FieldIdxW-1:0] idx,
                             input logic [KeyW-1:0] key, input logic [RposW-1:0] rpos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, rpos, key, idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (op != OP_IGNORED) items_sent++;
    endtask

    function automatic logic [KeyW-1:0] pick_key(int span);
        case (span)
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // mostly valid ranks, sometimes anywhere in the field
    function automatic logic [RposW-1:0] pick_rank();
        if (sb.fill > 0 && $urandom_range(0, 4) != 0)
            return RposW'($urandom_range(0, sb.fill - 1));
        return RposW'($urandom_range(0, 63));
    endfunction

    initial begin
        int span;
        int inserts;
        int goal;
        int roll;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, extremes, equal-head and equal-key placement
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_IGNORED, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_INSERT, 16'h0000, 32'hFFFF_FFFF, '0);
        send_item(OP_INSERT, 16'hFFFF, 32'h0000_0000, 6'd63);
        send_item(OP_INSERT, 16'h1234, 32'h0000_0000, '0);
        send_item(OP_INSERT, 16'hABCD, 32'h8000_0000, '0);
        send_item(OP_INSERT, 16'h5432, 32'h8000_0000, '0);
        for (int i = 0; i < 5; i++) send_item(OP_READ, '0, '0, i[RposW-1:0]);
        send_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_IGNORED, '0, '0, '0);
        send_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_INSERT, 16'h00FF, 32'd5, '0);
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_READ, '0, '0, 6'd1);
        send_item(OP_CLEAR, '0, '0, '0);

        // random rounds: usually start from a cleared list and often fill past capacity
        // so that evictions and rejections come up
        while (items_sent < ItemTarget) begin
            span = $urandom_range(0, 2);
            goal = $urandom_range(10, 110);
            inserts = 0;
            if ($urandom_range(0, 3) != 0)
                send_item(OP_CLEAR, FieldIdxW'($urandom), $urandom, RposW'($urandom));
            while (inserts < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 62) begin
                    send_item(OP_INSERT, FieldIdxW'($urandom), pick_key(span),
                              RposW'($urandom));
                    inserts++;
                end else if (roll < 92) begin
                    send_item(OP_READ, FieldIdxW'($urandom), $urandom, pick_rank());
                end else if (roll < 95) begin
                    send_item(OP_IGNORED, FieldIdxW'($urandom), $urandom, RposW'($urandom));
                end else if (roll < 97) begin
                    send_item(OP_CLEAR, FieldIdxW'($urandom), $urandom, RposW'($urandom));
                end else begin
                    send_item(OP_INSERT, FieldIdxW'($urandom),
                              ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0,
                              RposW'($urandom));
                    inserts++;
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
